// ===== rtl/lbed_pkg.sv =====
// ----------------------------------------------------------------------------
// lbed_pkg
// Shared types and constants of the ladder button event decoder: field
// widths, register indexes, event codes and controller states.
// ----------------------------------------------------------------------------
package lbed_pkg;

	// Default parameter values of the top level.
	localparam int DEF_MAX_BUTTONS = 8;
	localparam int DEF_ADC_BITS    = 12;

	// Fixed field widths.
	localparam int BTN_W      = 8;
	localparam int TIME_W     = 32;
	localparam int DELAY_W    = 16;
	localparam int NSAMP_W    = 8;
	localparam int TOL_W      = 12;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// Identifier that stands for "no button pressed".
	localparam logic [BTN_W-1:0] NO_BTN = 8'hFF;

	// Register reset values.
	localparam logic [DELAY_W-1:0] RST_DEBOUNCE      = 16'd50;
	localparam logic [DELAY_W-1:0] RST_HOLD_DELAY    = 16'd500;
	localparam logic [DELAY_W-1:0] RST_HOLD_INTERVAL = 16'd100;
	localparam logic [NSAMP_W-1:0] RST_NUM_SAMPLES   = 8'd4;
	localparam logic [TOL_W-1:0]   RST_TOLERANCE     = 12'd50;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_DEBOUNCE,
		CFG_HOLD_DELAY,
		CFG_HOLD_INTERVAL,
		CFG_NUM_SAMPLES,
		CFG_TOLERANCE
	} cfg_idx_t;

	// Event codes carried on the result channel.
	typedef enum logic [1:0] {
		EV_UP,
		EV_DOWN,
		EV_HELD
	} ev_kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_DB,
		ST_HOLD,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/lbed_ifs.sv =====
// ----------------------------------------------------------------------------
// lbed channel interfaces
// Valid/ready channels of the decoder: command requests in, event requests
// out, and the configuration write channel.
// ----------------------------------------------------------------------------

// Command channel: samples (mode 0) and table appends (mode 1).
interface lbed_cmd_if #(
	parameter int ADC_BITS = lbed_pkg::DEF_ADC_BITS
);
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [ADC_BITS-1:0]          adc_sample;
	logic [lbed_pkg::TIME_W-1:0]  now_ms;
	logic [lbed_pkg::BTN_W-1:0]   button_id;
	logic [ADC_BITS-1:0]          range_low;
	logic [ADC_BITS-1:0]          range_high;

	modport source (
		output valid, mode, adc_sample, now_ms, button_id, range_low, range_high,
		input  ready
	);
	modport sink (
		input  valid, mode, adc_sample, now_ms, button_id, range_low, range_high,
		output ready
	);
endinterface

// Event channel: released, pressed and held events.
interface lbed_evt_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 event_kind;
	logic [lbed_pkg::BTN_W-1:0] event_button;
	logic                       last_event;

	modport source (
		output valid, event_kind, event_button, last_event,
		input  ready
	);
	modport sink (
		input  valid, event_kind, event_button, last_event,
		output ready
	);
endinterface

// Configuration write channel.
interface lbed_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lbed_pkg::CFG_ADDR_W-1:0] index;
	logic [lbed_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== rtl/ladder_button_event_decoder.sv =====
// ----------------------------------------------------------------------------
// ladder_button_event_decoder
// Resistor ladder keypad decoder: sample averaging, table match, debounce,
// press, release, hold and auto-repeat events.
// ----------------------------------------------------------------------------
// Usage:
// Requests on cmd carry either a timestamped converter sample (mode 0) or a
// button table entry to append (mode 1). Events leave on evt, at most three
// per request, the final one marked by last_event. Registers are written on
// cfg, which is always ready; write only while the block is idle.
// cmd is ready whenever the controller is idle. A table append or a sample
// that does not complete a group is taken without leaving idle. A sample
// that completes a group passes through accept, the bit-serial divider, a
// scan of the table memory one entry per cycle up to the first match,
// debounce and hold evaluation, and the move of each event in turn into the
// output register. The output register holds the last event while the next
// request is taken; if evt stalls, the controller waits in its emit phase
// until the register frees. Reset restores register defaults, empties the
// table and clears debounce and hold state; table memory contents need no
// clearing.
// ----------------------------------------------------------------------------
module ladder_button_event_decoder #(
	parameter int MAX_BUTTONS = lbed_pkg::DEF_MAX_BUTTONS,
	parameter int ADC_BITS    = lbed_pkg::DEF_ADC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	lbed_cmd_if.sink      cmd,
	lbed_evt_if.source    evt,
	lbed_cfg_if.sink      cfg
);
	import lbed_pkg::*;

	localparam int SUM_W  = ADC_BITS + NSAMP_W;
	localparam int CMP_W  = SUM_W + 2;
	localparam int CNT_W  = $clog2(MAX_BUTTONS + 1);
	localparam int IDX_W  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int DCNT_W = $clog2(SUM_W);

	typedef struct packed {
		logic [BTN_W-1:0]    id;
		logic [ADC_BITS-1:0] lo;
		logic [ADC_BITS-1:0] hi;
	} entry_t;

	// Configuration registers.
	logic [DELAY_W-1:0] debounce_q, hold_delay_q, hold_interval_q;
	logic [NSAMP_W-1:0] num_samples_q;
	logic [TOL_W-1:0]   tol_q;

	// Control and timing state.
	state_t             state_q, state_d;
	logic [SUM_W-1:0]   sum_q;
	logic [NSAMP_W-1:0] count_q;
	logic [BTN_W-1:0]   pending_q, stable_q;
	logic [TIME_W-1:0]  db_start_q, hold_start_q, last_rep_q;
	logic               held_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic               rd_pend_q;
	logic               out_valid_q;

	// Working registers of one group.
	logic [SUM_W-1:0]   quo_q;
	logic [NSAMP_W-1:0] rem_q, divisor_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [TIME_W-1:0]  now_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic [BTN_W-1:0]   cur_q;
	entry_t             rd_q;
	ev_kind_t           ev_kind_q [3];
	logic [BTN_W-1:0]   ev_btn_q [3];
	logic [1:0]         ev_n_q, emit_idx_q;
	ev_kind_t           out_kind_q;
	logic [BTN_W-1:0]   out_btn_q;
	logic               out_last_q;

	// Button table memory.
	entry_t             mem [MAX_BUTTONS];

	// Accept and grouping.
	logic               cmd_fire, cfg_fire, tbl_wr, group_done;
	logic [SUM_W-1:0]   sum_next;
	logic [NSAMP_W-1:0] count_next, group;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign cmd_fire   = cmd.valid && (state_q == ST_IDLE);
	assign cfg_fire   = cfg.valid;
	assign tbl_wr     = cmd_fire && cmd.mode && (entry_count_q < CNT_W'(MAX_BUTTONS));
	assign sum_next   = sum_q + SUM_W'(cmd.adc_sample);
	assign count_next = count_q + 1'b1;
	assign group      = (num_samples_q == '0) ? NSAMP_W'(1) : num_samples_q;
	assign group_done = (count_next >= group);

	// Divider step: shift in one dividend bit, subtract if it fits.
	logic [NSAMP_W:0]   div_shift, div_diff;
	logic               div_bit;

	assign div_shift = {rem_q, quo_q[SUM_W-1]};
	assign div_diff  = div_shift - {1'b0, divisor_q};
	assign div_bit   = !div_diff[NSAMP_W];

	// Table scan: signed range test against the widened bounds.
	logic               scan_issue, scan_hit;
	logic [IDX_W-1:0]   rd_addr;
	logic signed [CMP_W-1:0] avg_v, lo_v, hi_v;

	assign scan_issue = (scan_idx_q < entry_count_q);
	assign rd_addr    = scan_issue ? scan_idx_q[IDX_W-1:0] : '0;
	assign avg_v      = CMP_W'(quo_q);
	assign lo_v       = CMP_W'(rd_q.lo) - CMP_W'(tol_q);
	assign hi_v       = CMP_W'(rd_q.hi) + CMP_W'(tol_q);
	assign scan_hit   = rd_pend_q && (avg_v >= lo_v) && (avg_v <= hi_v);

	// Debounce decision.
	logic               db_fire, up_ev, down_ev;
	logic [TIME_W-1:0]  db_start_v, db_elapsed;

	assign db_start_v = (cur_q != pending_q) ? now_q : db_start_q;
	assign db_elapsed = now_q - db_start_v;
	assign db_fire    = (db_elapsed >= TIME_W'(debounce_q)) && (stable_q != cur_q);
	assign up_ev      = db_fire && (stable_q != NO_BTN);
	assign down_ev    = db_fire && (cur_q != NO_BTN);

	// Hold and repeat decision.
	logic               first_held, repeat_held, hold_emit;
	logic [TIME_W-1:0]  hold_elapsed, rep_elapsed;

	assign hold_elapsed = now_q - hold_start_q;
	assign rep_elapsed  = now_q - last_rep_q;
	assign first_held   = (stable_q != NO_BTN) && !held_q &&
		(hold_elapsed >= TIME_W'(hold_delay_q));
	assign repeat_held  = (stable_q != NO_BTN) && held_q && (hold_interval_q != '0) &&
		(rep_elapsed >= TIME_W'(hold_interval_q));
	assign hold_emit    = first_held || repeat_held;

	// Emit into the output register.
	logic               emit_load, emit_last;

	assign emit_last = (emit_idx_q == (ev_n_q - 2'd1));
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || evt.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && !cmd.mode && group_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_hit || !scan_issue) state_d = ST_DB;
			end
			ST_DB: state_d = ST_HOLD;
			ST_HOLD: begin
				state_d = ((ev_n_q != 2'd0) || hold_emit) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_load && emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= RST_DEBOUNCE;
			hold_delay_q    <= RST_HOLD_DELAY;
			hold_interval_q <= RST_HOLD_INTERVAL;
			num_samples_q   <= RST_NUM_SAMPLES;
			tol_q           <= RST_TOLERANCE;
		end else if (cfg_fire) begin
			case (cfg.index)
				CFG_DEBOUNCE:      debounce_q      <= cfg.data[DELAY_W-1:0];
				CFG_HOLD_DELAY:    hold_delay_q    <= cfg.data[DELAY_W-1:0];
				CFG_HOLD_INTERVAL: hold_interval_q <= cfg.data[DELAY_W-1:0];
				CFG_NUM_SAMPLES:   num_samples_q   <= cfg.data[NSAMP_W-1:0];
				CFG_TOLERANCE:     tol_q           <= cfg.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Table memory: appends in idle, one registered read per scan cycle.
	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			mem[entry_count_q[IDX_W-1:0]] <= '{id: cmd.button_id, lo: cmd.range_low,
				hi: cmd.range_high};
		end
		rd_q <= mem[rd_addr];
	end

	// Control state: grouping, table fill, debounce, hold and repeat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			count_q       <= '0;
			pending_q     <= NO_BTN;
			stable_q      <= NO_BTN;
			db_start_q    <= '0;
			hold_start_q  <= '0;
			held_q        <= 1'b0;
			last_rep_q    <= '0;
			entry_count_q <= '0;
			rd_pend_q     <= 1'b0;
		end else begin
			if (tbl_wr) entry_count_q <= entry_count_q + 1'b1;
			if (cmd_fire && !cmd.mode) begin
				sum_q   <= group_done ? '0 : sum_next;
				count_q <= group_done ? '0 : count_next;
			end
			rd_pend_q <= (state_q == ST_SCAN) && scan_issue;
			if (state_q == ST_DB) begin
				pending_q  <= cur_q;
				db_start_q <= db_start_v;
				if (db_fire) begin
					stable_q <= cur_q;
					held_q   <= 1'b0;
				end
				if (down_ev) hold_start_q <= now_q;
			end
			if (state_q == ST_HOLD) begin
				if (first_held) held_q <= 1'b1;
				if (hold_emit) last_rep_q <= now_q;
			end
		end
	end

	// Working registers of the divider, scan and event list.
	always_ff @(posedge clk) begin
		if (cmd_fire && !cmd.mode && group_done) begin
			quo_q     <= sum_next;
			rem_q     <= '0;
			divisor_q <= group;
			div_cnt_q <= DCNT_W'(SUM_W - 1);
			now_q     <= cmd.now_ms;
		end
		if (state_q == ST_DIV) begin
			quo_q     <= {quo_q[SUM_W-2:0], div_bit};
			rem_q     <= div_bit ? div_diff[NSAMP_W-1:0] : div_shift[NSAMP_W-1:0];
			div_cnt_q <= div_cnt_q - 1'b1;
			scan_idx_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (scan_issue) scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_hit) begin
				cur_q <= rd_q.id;
			end else if (!scan_issue) begin
				cur_q <= NO_BTN;
			end
		end
		if (state_q == ST_DB) begin
			ev_kind_q[0] <= up_ev ? EV_UP : EV_DOWN;
			ev_btn_q[0]  <= up_ev ? stable_q : cur_q;
			ev_kind_q[1] <= EV_DOWN;
			ev_btn_q[1]  <= cur_q;
			ev_n_q       <= {1'b0, up_ev} + {1'b0, down_ev};
			emit_idx_q   <= '0;
		end
		if ((state_q == ST_HOLD) && hold_emit) begin
			ev_kind_q[ev_n_q] <= EV_HELD;
			ev_btn_q[ev_n_q]  <= stable_q;
			ev_n_q            <= ev_n_q + 2'd1;
		end
		if (emit_load) begin
			out_kind_q <= ev_kind_q[emit_idx_q];
			out_btn_q  <= ev_btn_q[emit_idx_q];
			out_last_q <= emit_last;
			emit_idx_q <= emit_idx_q + 2'd1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_kind   = out_kind_q;
	assign evt.event_button = out_btn_q;
	assign evt.last_event   = out_last_q;

	// Requests are taken only by the idle controller.
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> (state_q == ST_IDLE))
		else $error("command request taken while busy");

	// The table never holds more than its depth.
	a_tbl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_BUTTONS))
		else $error("table entry count beyond depth");

	// The no-button code never appears in an event.
	a_no_btn_evt: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> (evt.event_button != NO_BTN))
		else $error("event for the no-button code");

	// The emit phase always has events to move.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ev_n_q != 2'd0))
		else $error("emit phase with empty event list");

	// Loading the final event of a request returns the controller to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> (state_q == ST_IDLE) && evt.valid && evt.last_event)
		else $error("final event did not close the request");

endmodule

// ===== tb/sv/tb_ladder_button_event_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ladder_button_event_decoder
// Self-checking bench for the ladder button event decoder. Samples and table
// appends go in on the command channel; a predictor tracks averaging, table
// match, debounce, hold and repeat, and every event that comes out is
// compared against the oldest predicted one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ladder_button_event_decoder;
	import lbed_pkg::*;

	localparam int MAX_BUTTONS   = DEF_MAX_BUTTONS;
	localparam int ADC_BITS      = DEF_ADC_BITS;
	localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_REPORTS   = 30;
	localparam int RUN_LIMIT_NS  = 10_000_000;

	// One command request and one decoder event.
	typedef struct {
		logic                mode;
		logic [ADC_BITS-1:0] adc;
		logic [TIME_W-1:0]   now;
		logic [BTN_W-1:0]    id;
		logic [ADC_BITS-1:0] lo;
		logic [ADC_BITS-1:0] hi;
	} ladder_req_t;

	typedef struct {
		ev_kind_t         kind;
		logic [BTN_W-1:0] button;
		logic             last;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n;

	lbed_cmd_if #(.ADC_BITS(ADC_BITS)) cmd_if ();
	lbed_evt_if evt_if ();
	lbed_cfg_if cfg_if ();

	ladder_button_event_decoder #(
		.MAX_BUTTONS(MAX_BUTTONS),
		.ADC_BITS   (ADC_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.evt   (evt_if),
		.cfg   (cfg_if)
	);

	always #10 clk = ~clk;

	// Register shadows, starting at their reset values.
	logic [DELAY_W-1:0] dly_debounce = RST_DEBOUNCE;
	logic [DELAY_W-1:0] dly_hold     = RST_HOLD_DELAY;
	logic [DELAY_W-1:0] dly_interval = RST_HOLD_INTERVAL;
	logic [NSAMP_W-1:0] nsamp_shadow = RST_NUM_SAMPLES;
	logic [TOL_W-1:0]   tol_shadow   = RST_TOLERANCE;

	// Decoder state as predicted.
	logic [19:0]         sum_acc    = '0;
	logic [7:0]          sum_count  = '0;
	logic [BTN_W-1:0]    cand_btn   = NO_BTN;
	logic [TIME_W-1:0]   cand_since = '0;
	logic [BTN_W-1:0]    stable_btn = NO_BTN;
	logic [TIME_W-1:0]   press_time = '0;
	logic [TIME_W-1:0]   repeat_time = '0;
	logic                held       = 1'b0;
	int unsigned         table_fill = 0;
	logic [BTN_W-1:0]    tbl_id [MAX_BUTTONS];
	logic [ADC_BITS-1:0] tbl_lo [MAX_BUTTONS];
	logic [ADC_BITS-1:0] tbl_hi [MAX_BUTTONS];

	key_event_t key_events_due[$];
	key_event_t due_event;

	// Bench controls and tallies.
	bit                sender_idles    = 1'b1;
	bit                receiver_stalls = 1'b1;
	int unsigned       stall_left      = 0;
	logic [TIME_W-1:0] ms_clock        = '0;
	int unsigned       fail_count      = 0;
	int unsigned       events_seen     = 0;
	int unsigned       requests_sent   = 0;
	int unsigned       appends_sent    = 0;

	// First table entry whose widened range holds the level, signed compare.
	function automatic logic [BTN_W-1:0] ladder_lookup(input int unsigned level);
		int low_edge;
		int high_edge;
		for (int i = 0; i < int'(table_fill); i++) begin
			low_edge  = int'(tbl_lo[i]) - int'(tol_shadow);
			high_edge = int'(tbl_hi[i]) + int'(tol_shadow);
			if (int'(level) >= low_edge && int'(level) <= high_edge)
				return tbl_id[i];
		end
		return NO_BTN;
	endfunction

	// Add one event, not yet marked as final, to the end of a list.
	function automatic void add_key_event(ref key_event_t list[$], input ev_kind_t kind,
			input logic [BTN_W-1:0] button);
		key_event_t ev;
		ev.kind   = kind;
		ev.button = button;
		ev.last   = 1'b0;
		list = {list, ev};
	endfunction

	// Advance the predicted state by one accepted request and queue its events.
	function automatic void decode_ladder_request(input ladder_req_t r);
		int unsigned       group;
		int unsigned       level;
		logic [BTN_W-1:0]  hit;
		logic [BTN_W-1:0]  prev;
		logic [TIME_W-1:0] elapsed;
		key_event_t        found[$];
		if (r.mode) begin
			if (table_fill < MAX_BUTTONS) begin
				tbl_id[table_fill] = r.id;
				tbl_lo[table_fill] = r.lo;
				tbl_hi[table_fill] = r.hi;
				table_fill++;
			end
			return;
		end
		sum_acc = sum_acc + r.adc;
		sum_count = sum_count + 8'd1;
		group = (nsamp_shadow == 0) ? 1 : nsamp_shadow;
		if (sum_count < group)
			return;
		level = sum_acc / group;
		sum_acc = '0;
		sum_count = '0;
		hit = ladder_lookup(level);

		// Debounce: a new match restarts the timer, a settled one takes over.
		if (hit != cand_btn) begin
			cand_btn = hit;
			cand_since = r.now;
		end
		elapsed = r.now - cand_since;
		if (elapsed >= dly_debounce && stable_btn != cand_btn) begin
			prev = stable_btn;
			stable_btn = cand_btn;
			if (prev != NO_BTN) begin
				add_key_event(found, EV_UP, prev);
				held = 1'b0;
			end
			if (stable_btn != NO_BTN) begin
				add_key_event(found, EV_DOWN, stable_btn);
				press_time = r.now;
				held = 1'b0;
			end
		end

		// Hold after the delay, then repeat at the interval unless it is zero.
		if (stable_btn != NO_BTN) begin
			elapsed = r.now - press_time;
			if (!held && elapsed >= dly_hold) begin
				held = 1'b1;
				add_key_event(found, EV_HELD, stable_btn);
				repeat_time = r.now;
			end else if (held && dly_interval != 0) begin
				elapsed = r.now - repeat_time;
				if (elapsed >= dly_interval) begin
					add_key_event(found, EV_HELD, stable_btn);
					repeat_time = r.now;
				end
			end
		end

		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		key_events_due = {key_events_due, found};
	endfunction

	// Offer one request, idling at random first, and predict it once taken.
	task automatic send_request(input ladder_req_t r);
		while (sender_idles && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			cmd_if.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_if.valid      <= 1'b1;
		cmd_if.mode       <= r.mode;
		cmd_if.adc_sample <= r.adc;
		cmd_if.now_ms     <= r.now;
		cmd_if.button_id  <= r.id;
		cmd_if.range_low  <= r.lo;
		cmd_if.range_high <= r.hi;
		do @(posedge clk); while (!cmd_if.ready);
		decode_ladder_request(r);
		requests_sent++;
		if (r.mode)
			appends_sent++;
	endtask

	// A sample request; the table fields carry random noise.
	task automatic send_sample(input int adc, input logic [TIME_W-1:0] now);
		ladder_req_t r;
		r.mode = 1'b0;
		r.adc  = adc[ADC_BITS-1:0];
		r.now  = now;
		r.id   = BTN_W'($urandom_range(0, 255));
		r.lo   = ADC_BITS'($urandom_range(0, ADC_MAX));
		r.hi   = ADC_BITS'($urandom_range(0, ADC_MAX));
		send_request(r);
	endtask

	task automatic append_entry(input logic [BTN_W-1:0] id, input int lo, input int hi);
		ladder_req_t r;
		r.mode = 1'b1;
		r.adc  = ADC_BITS'($urandom_range(0, ADC_MAX));
		r.now  = $urandom();
		r.id   = id;
		r.lo   = lo[ADC_BITS-1:0];
		r.hi   = hi[ADC_BITS-1:0];
		send_request(r);
	endtask

	// Wait until every predicted event has arrived, then let the block settle.
	task automatic drain_events();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (key_events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_DEBOUNCE:      dly_debounce = val;
			CFG_HOLD_DELAY:    dly_hold = val;
			CFG_HOLD_INTERVAL: dly_interval = val;
			CFG_NUM_SAMPLES:   nsamp_shadow = val[NSAMP_W-1:0];
			CFG_TOLERANCE:     tol_shadow = val[TOL_W-1:0];
			default:           ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic apply_settings(input int debounce, input int hold_dly,
			input int interval, input int nsamp, input int tol);
		drain_events();
		write_reg(CFG_DEBOUNCE, CFG_DATA_W'(debounce));
		write_reg(CFG_HOLD_DELAY, CFG_DATA_W'(hold_dly));
		write_reg(CFG_HOLD_INTERVAL, CFG_DATA_W'(interval));
		write_reg(CFG_NUM_SAMPLES, CFG_DATA_W'(nsamp));
		write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
	endtask

	// Key presses: runs of samples near one entry's range, with glitches,
	// time jumps, stray appends and the odd pause until all events are in.
	task automatic play_gestures(input int unsigned n_samples);
		int unsigned sent;
		int unsigned slot;
		int unsigned run_len;
		int          center;
		int          adc;
		sent = 0;
		while (sent < n_samples) begin
			slot = $urandom_range(0, MAX_BUTTONS + 1);
			if (slot < table_fill)
				center = (int'(tbl_lo[slot]) + int'(tbl_hi[slot])) / 2;
			else
				center = $urandom_range(0, ADC_MAX);
			run_len = $urandom_range(1, 10) * ((nsamp_shadow == 0) ? 1 : nsamp_shadow);
			for (int k = 0; k < int'(run_len) && sent < n_samples; k++) begin
				if ($urandom_range(0, 9) == 0)
					adc = $urandom_range(0, ADC_MAX);
				else
					adc = center + int'($urandom_range(0, 80)) - 40;
				if (adc < 0)
					adc = 0;
				if (adc > ADC_MAX)
					adc = ADC_MAX;
				if ($urandom_range(0, 49) == 0)
					ms_clock = ms_clock + $urandom();
				else
					ms_clock = ms_clock + $urandom_range(0, 45);
				send_sample(adc, ms_clock);
				sent++;
				if ($urandom_range(0, 29) == 0)
					append_entry(BTN_W'($urandom_range(0, 255)),
						$urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX));
			end
			if ($urandom_range(0, 24) == 0)
				drain_events();
		end
	endtask

	// With no table every group averages to no button.
	task automatic test_empty_table();
		send_sample(0, 0);
		send_sample(ADC_MAX, 0);
		send_sample(ADC_MAX, 0);
		send_sample(0, 0);
	endtask

	// Fill the table, including an overlap, the no-button id and both range
	// extremes, then offer appends that a full table must drop.
	task automatic test_table_fill();
		append_entry(8'h00, 0, 0);
		append_entry(8'h11, 300, 700);
		append_entry(8'h22, 650, 1100);
		append_entry(8'h44, 1300, 1700);
		append_entry(NO_BTN, 1900, 2300);
		append_entry(8'h88, 2500, 2900);
		append_entry(8'h5A, 3100, 3500);
		append_entry(8'hFE, ADC_MAX, ADC_MAX);
		append_entry(NO_BTN, ADC_MAX, 0);
		append_entry(8'h77, 12'hABC, 12'h123);
		append_entry(8'h01, 0, ADC_MAX);
	endtask

	// Zero delays and single-sample groups: every press gives press and held
	// at once, a change of key gives three events, the no-button id releases.
	task automatic test_immediate_events();
		apply_settings(0, 0, 0, 1, 50);
		ms_clock = 32'd100;
		send_sample(500, ms_clock);
		send_sample(680, ms_clock + 10);
		send_sample(900, ms_clock + 20);
		send_sample(2000, ms_clock + 30);
		send_sample(0, ms_clock + 40);
		send_sample(ADC_MAX, ms_clock + 50);
		send_sample(3600, ms_clock + 60);
		ms_clock = ms_clock + 60;
	endtask

	// Shrink the group size below the samples already summed.
	task automatic test_group_shrink();
		drain_events();
		write_reg(CFG_NUM_SAMPLES, CFG_DATA_W'(255));
		send_sample(ADC_MAX, ms_clock);
		send_sample(ADC_MAX, ms_clock);
		send_sample(ADC_MAX, ms_clock);
		drain_events();
		write_reg(CFG_NUM_SAMPLES, CFG_DATA_W'(2));
		send_sample(ADC_MAX, ms_clock);
	endtask

	task automatic test_random_defaults();
		apply_settings(RST_DEBOUNCE, RST_HOLD_DELAY, RST_HOLD_INTERVAL,
			RST_NUM_SAMPLES, RST_TOLERANCE);
		play_gestures(100);
	endtask

	// No idling on either side, with the time base wrapping past zero.
	task automatic test_random_steady();
		apply_settings(0, 200, 0, 1, 0);
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		ms_clock = 32'hFFFF_FF00;
		play_gestures(60);
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	task automatic test_random_mixed();
		repeat (4) begin
			apply_settings($urandom_range(0, 120), $urandom_range(0, 800),
				$urandom_range(0, 150), $urandom_range(0, 6), $urandom_range(0, 200));
			play_gestures(30);
		end
	endtask

	task automatic test_extreme_settings();
		apply_settings(16'hFFFF, 0, 1, 2, 4095);
		play_gestures(25);
		apply_settings(0, 16'hFFFF, 16'hFFFF, 0, 0);
		play_gestures(20);
	endtask

	// Long output stall while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		apply_settings(0, 0, 1, 1, 50);
		sender_idles = 1'b0;
		stall_left = 300;
		play_gestures(30);
		sender_idles = 1'b1;
	endtask

	// Event receiver: a counted hold-off, random stalls, or always ready.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			evt_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (receiver_stalls) begin
			evt_if.ready <= ($urandom_range(0, 99) >= 37);
		end else begin
			evt_if.ready <= 1'b1;
		end
	end

	// Compare each event taken with the oldest predicted one.
	always @(posedge clk) begin
		if (arst_n && evt_if.valid && evt_if.ready) begin
			events_seen++;
			if (key_events_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: event with none due, kind %0d button %02h last %0b",
						$time, evt_if.event_kind, evt_if.event_button, evt_if.last_event);
			end else begin
				due_event = key_events_due.pop_front();
				if (evt_if.event_kind !== due_event.kind) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: event_kind expected %0d, got %0d",
							$time, due_event.kind, evt_if.event_kind);
				end
				if (evt_if.event_button !== due_event.button) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: event_button expected %02h, got %02h",
							$time, due_event.button, evt_if.event_button);
				end
				if (evt_if.last_event !== due_event.last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: last_event expected %0b, got %0b",
							$time, due_event.last, evt_if.last_event);
				end
			end
		end
	end

	// Run limit.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d events still due", key_events_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.mode       = 1'b0;
		cmd_if.adc_sample = '0;
		cmd_if.now_ms     = '0;
		cmd_if.button_id  = '0;
		cmd_if.range_low  = '0;
		cmd_if.range_high = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = CFG_DEBOUNCE;
		cfg_if.data       = '0;
		evt_if.ready      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_table_fill();
		test_immediate_events();
		test_group_shrink();
		test_random_defaults();
		test_random_steady();
		test_random_mixed();
		test_extreme_settings();
		test_backpressure();
		drain_events();

		$display("Sent %0d requests (%0d table appends) and checked %0d key events.",
			requests_sent, appends_sent, events_seen);
		$display("Covered zero and full-scale delays, groups of 0 to 255, a long stall.");
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
